FILE: src/fpba_pkg.sv
// Shared types and constants of the fit-policy block allocator.
// Holds the controller state, the command and status structs and the code values.
// No dependencies.
package fpba_pkg;

	localparam int LOAD_IDX_W = 4;
	localparam int SIZE_IN_W  = 16;
	localparam int BLOCK_ID_W = 4;
	localparam int POLICY_W   = 2;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

	localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

	localparam logic [POLICY_W-1:0] FIT_POLICY_RESET  = POLICY_FIRST;
	localparam logic [COUNT_W-1:0]  BLOCK_COUNT_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_entry;
		logic begin_alloc;
		logic issue_read;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} status_t;

endpackage

FILE: src/fpba_ctrl.sv
// Controller of the fit-policy block allocator.
// Sequences load, scan and write back; drives fpba_datapath through cmd_t.
// Depends on fpba_pkg.
module fpba_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             mode,
	input  fpba_pkg::status_t sts,
	output fpba_pkg::cmd_t   cmd,
	output logic             busy
);
	import fpba_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		busy      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (mode == MODE_ALLOC) begin
						cmd.begin_alloc = 1'b1;
						state_nxt       = ST_SCAN;
					end else begin
						cmd.load_entry = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = ST_FINISH;
				end else begin
					cmd.issue_read = 1'b1;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: src/fpba_datapath.sv
// Datapath of the fit-policy block allocator: free size table, config registers,
// scan pipeline with best-candidate tracking, write back and result registers.
// Depends on fpba_pkg; commanded by fpba_ctrl.
module fpba_datapath #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fpba_pkg::cmd_t                       cmd,
	output fpba_pkg::status_t                    sts,
	input  logic                                 cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic [fpba_pkg::LOAD_IDX_W-1:0]      load_index,
	input  logic [fpba_pkg::SIZE_IN_W-1:0]       size_value,
	output logic                                 done,
	output logic                                 granted,
	output logic [fpba_pkg::BLOCK_ID_W-1:0]      chosen_block,
	output logic [fpba_pkg::SIZE_IN_W-1:0]       remaining_free
);
	import fpba_pkg::*;

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];

	logic [POLICY_W-1:0]  fit_policy_q;
	logic [COUNT_W-1:0]   block_count_q;
	logic [CNT_W-1:0]     limit;
	logic [CNT_W-1:0]     addr_q;
	logic [SIZE_BITS-1:0] req_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_val_q;
	logic                 rd_valid_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [SIZE_BITS-1:0] rd_data_s1;
	logic [SIZE_BITS-1:0] left;
	logic                 fits;
	logic                 better;
	logic                 take;
	logic                 load_ok;
	logic                 done_q;
	logic                 granted_q;
	logic [BLOCK_ID_W-1:0] chosen_q;
	logic [SIZE_IN_W-1:0] remaining_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q  <= FIT_POLICY_RESET;
			block_count_q <= BLOCK_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIT_POLICY:  fit_policy_q  <= cfg_wdata[POLICY_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= cfg_wdata[COUNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (32'(block_count_q) > NUM_BLOCKS) begin
			limit = CNT_W'(NUM_BLOCKS);
		end else begin
			limit = CNT_W'(block_count_q);
		end
	end

	assign sts.scan_done = (addr_q == limit);

	assign load_ok = (32'(load_index) < NUM_BLOCKS);
	assign left    = best_val_q - req_q;

	always_ff @(posedge clk) begin
		if (cmd.load_entry && load_ok) begin
			mem[IDX_W'(load_index)] <= SIZE_BITS'(size_value);
		end else if (cmd.finish && found_q) begin
			mem[best_idx_q] <= left;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue_read) begin
			rd_data_s1 <= mem[addr_q[IDX_W-1:0]];
			rd_idx_s1  <= addr_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			addr_q      <= '0;
		end else begin
			rd_valid_s1 <= cmd.issue_read;
			if (cmd.begin_alloc) begin
				addr_q <= '0;
			end else if (cmd.issue_read) begin
				addr_q <= addr_q + CNT_W'(1);
			end
		end
	end

	assign fits = (rd_data_s1 >= req_q);

	always_comb begin
		if (!found_q) begin
			better = 1'b1;
		end else if (fit_policy_q == POLICY_BEST) begin
			better = (rd_data_s1 < best_val_q);
		end else if (fit_policy_q == POLICY_WORST) begin
			better = (rd_data_s1 > best_val_q);
		end else begin
			better = 1'b0;
		end
	end

	assign take = rd_valid_s1 && fits && better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.begin_alloc) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.begin_alloc) begin
			req_q <= SIZE_BITS'(size_value);
		end
		if (take) begin
			best_idx_q <= rd_idx_s1;
			best_val_q <= rd_data_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			granted_q <= found_q;
			if (found_q) begin
				chosen_q    <= BLOCK_ID_W'(best_idx_q);
				remaining_q <= SIZE_IN_W'(left);
			end else begin
				chosen_q    <= '0;
				remaining_q <= '0;
			end
		end
	end

	assign done           = done_q;
	assign granted        = granted_q;
	assign chosen_block   = chosen_q;
	assign remaining_free = remaining_q;

endmodule

FILE: src/fit_policy_block_allocator_top.sv
// Fit-policy block allocator top level: first, best or worst fit over a free size table.
// Load: no result. Allocate: scan of the table, then write back and result strobe on done,
// L = min(block_count, NUM_BLOCKS) entries are scanned; next item taken when done is high.
// The scan reads one table entry per cycle through the single read port.
// Reset clears the controller, the result strobe and sets fit_policy 0, block_count 16;
// the table is not cleared. The receiver cannot stall; done is high for one cycle.
module fit_policy_block_allocator_top #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 mode,
	input  logic [fpba_pkg::LOAD_IDX_W-1:0]      load_index,
	input  logic [fpba_pkg::SIZE_IN_W-1:0]       size_value,
	input  logic                                 cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output logic                                 done,
	output logic                                 granted,
	output logic [fpba_pkg::BLOCK_ID_W-1:0]      chosen_block,
	output logic [fpba_pkg::SIZE_IN_W-1:0]       remaining_free
);
	import fpba_pkg::*;

	cmd_t    cmd;
	status_t sts;

	fpba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	fpba_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.load_index     (load_index),
		.size_value     (size_value),
		.done           (done),
		.granted        (granted),
		.chosen_block   (chosen_block),
		.remaining_free (remaining_free)
	);

endmodule
